FILE: hdl/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg: shared types for the tagged request queue
// request op codes, result status codes, sequencer states, storage entry
// and the command group sent to the entry store
// ----------------------------------------------------------------------------
package trq_pkg;

	localparam int ID_W     = 31;
	localparam int HANDLE_W = 32;

	typedef enum logic [1:0] {
		OP_ENQ        = 2'd0,
		OP_DEQ        = 2'd1,
		OP_CANCEL     = 2'd2,
		OP_CANCEL_ALL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]     tag;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// wr_en: write this cycle, shift: move the last read entry one place down
	typedef struct packed {
		logic wr_en;
		logic shift;
	} store_cmd_t;

endpackage

FILE: hdl/trq_store.sv
// ----------------------------------------------------------------------------
// trq_store: entry storage of the tagged request queue
// circular entry array with a registered read port, one shared
// head-plus-offset wrap adder that forms every slot address
// ----------------------------------------------------------------------------
module trq_store import trq_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int SLOT_W = 4,
	parameter int CNT_W  = 5
) (
	input  logic              clk,
	input  logic [SLOT_W-1:0] head,
	input  logic [CNT_W-1:0]  ptr,
	input  store_cmd_t        cmd,
	input  entry_t            wr_entry,
	output entry_t            rd_entry,
	output logic [SLOT_W-1:0] slot
);

	localparam int SUM_W = CNT_W + 1;

	entry_t            mem [DEPTH];
	entry_t            rd_q;
	logic [SLOT_W-1:0] a_q;
	logic [SLOT_W-1:0] b_q;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  wrapped;
	logic [SLOT_W-1:0] wr_slot;
	entry_t            wr_data;

	// head + offset stays below twice the depth: one compare and subtract
	assign sum     = SUM_W'(head) + SUM_W'(ptr);
	assign wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
	assign slot    = wrapped[SLOT_W-1:0];

	// shift writes the entry just read into the slot read one step earlier
	assign wr_slot = cmd.shift ? b_q : slot;
	assign wr_data = cmd.shift ? rd_q : wr_entry;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		rd_q <= mem[slot];
		a_q  <= slot;
		b_q  <= a_q;
	end

	assign rd_entry = rd_q;

endmodule

FILE: hdl/tagged_request_queue_top.sv
// ----------------------------------------------------------------------------
// tagged_request_queue_top: ordered queue of tagged request handles
// enqueue, dequeue oldest, cancel by id and cancel all over a circular store
// ----------------------------------------------------------------------------
// enqueue writes the tail on accept and then shows its result, dequeue reads the
//   head in S_SCAN, cancel by id scans from the head until a hit or the youngest
//   entry; a hit in the middle is closed up by S_SHIFT, one place per younger entry
// cancel all removes the head, shows it and goes on with the next head while the output takes them
// throughput: one request at a time, set by the single store read port and the
//   scan sequencer; in_ready returns the cycle after the last result is taken
// reset: arst_n clears sequencer, head, count and id counter; the store is not cleared
module tagged_request_queue_top import trq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [HANDLE_W-1:0] req_handle,
	input  logic [ID_W-1:0]     target_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [ID_W-1:0]     entry_id,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                canceled,
	output logic                last
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// sequencer and queue bookkeeping
	state_t              state_q, state_nxt;
	op_t                 op_q, op_nxt;
	logic [ID_W-1:0]     tgt_q, tgt_nxt;
	logic [SLOT_W-1:0]   hd_q, hd_nxt;
	logic [CNT_W-1:0]    occ_q, occ_nxt;
	logic [CNT_W-1:0]    idx_q, idx_nxt;
	logic [ID_W-1:0]     id_q, id_nxt;

	// result register, shown on the output while in S_RESULT
	status_t             res_status_q, res_status_nxt;
	logic [ID_W-1:0]     res_id_q, res_id_nxt;
	logic [HANDLE_W-1:0] res_handle_q, res_handle_nxt;
	logic                res_canc_q, res_canc_nxt;
	logic                res_last_q, res_last_nxt;

	// store interface
	logic [CNT_W-1:0]    ptr;
	store_cmd_t          cmd;
	entry_t              wr_entry;
	entry_t              rd_entry;
	logic [SLOT_W-1:0]   slot;

	logic [CNT_W-1:0]    idx_inc;
	logic                hit;
	op_t                 in_op;

	assign idx_inc = idx_q + CNT_W'(1);
	assign in_op   = op_t'(op);

	trq_store #(
		.DEPTH  (QUEUE_DEPTH),
		.SLOT_W (SLOT_W),
		.CNT_W  (CNT_W)
	) u_store (
		.clk      (clk),
		.head     (hd_q),
		.ptr      (ptr),
		.cmd      (cmd),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.slot     (slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hd_q    <= '0;
			occ_q   <= '0;
			id_q    <= '0;
			idx_q   <= '0;
			op_q    <= OP_ENQ;
		end else begin
			state_q <= state_nxt;
			hd_q    <= hd_nxt;
			occ_q   <= occ_nxt;
			id_q    <= id_nxt;
			idx_q   <= idx_nxt;
			op_q    <= op_nxt;
		end
	end

	always_ff @(posedge clk) begin
		tgt_q        <= tgt_nxt;
		res_status_q <= res_status_nxt;
		res_id_q     <= res_id_nxt;
		res_handle_q <= res_handle_nxt;
		res_canc_q   <= res_canc_nxt;
		res_last_q   <= res_last_nxt;
	end

	always_comb begin
		state_nxt      = state_q;
		op_nxt         = op_q;
		tgt_nxt        = tgt_q;
		hd_nxt         = hd_q;
		occ_nxt        = occ_q;
		idx_nxt        = idx_q;
		id_nxt         = id_q;
		res_status_nxt = res_status_q;
		res_id_nxt     = res_id_q;
		res_handle_nxt = res_handle_q;
		res_canc_nxt   = res_canc_q;
		res_last_nxt   = res_last_q;
		ptr            = '0;
		cmd            = '0;
		wr_entry       = '{tag: id_q, handle: req_handle};
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		// remove the head for dequeue and cancel all, else match the tag
		hit            = (op_q != OP_CANCEL) || (rd_entry.tag == tgt_q);

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				// enqueue addresses the tail, everything else reads the head
				ptr = (in_op == OP_ENQ) ? occ_q : '0;
				if (in_valid) begin
					op_nxt         = in_op;
					tgt_nxt        = target_id;
					res_id_nxt     = '0;
					res_handle_nxt = '0;
					res_canc_nxt   = 1'b0;
					res_last_nxt   = 1'b1;
					if (in_op == OP_ENQ) begin
						state_nxt = S_RESULT;
						if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
							res_status_nxt = STATUS_FULL;
						end else begin
							cmd.wr_en      = 1'b1;
							res_status_nxt = STATUS_OK;
							res_id_nxt     = id_q;
							id_nxt         = id_q + ID_W'(1);
							occ_nxt        = occ_q + CNT_W'(1);
						end
					end else if (occ_q == '0) begin
						res_status_nxt = STATUS_MISS;
						state_nxt      = S_RESULT;
					end else begin
						idx_nxt   = '0;
						state_nxt = S_SCAN;
					end
				end
			end

			S_SCAN: begin
				// read data is queue position idx_q, prefetch the next one
				ptr = idx_inc;
				if (hit) begin
					res_status_nxt = STATUS_OK;
					res_id_nxt     = rd_entry.tag;
					res_handle_nxt = rd_entry.handle;
					res_canc_nxt   = (op_q != OP_DEQ);
					res_last_nxt   = (op_q != OP_CANCEL_ALL) || (occ_q == CNT_W'(1));
					if (idx_q == '0) begin
						// oldest entry leaves: head moves on by one
						hd_nxt    = slot;
						occ_nxt   = occ_q - CNT_W'(1);
						state_nxt = S_RESULT;
					end else if (idx_inc == occ_q) begin
						// youngest entry leaves: nothing to close up
						occ_nxt   = occ_q - CNT_W'(1);
						state_nxt = S_RESULT;
					end else begin
						idx_nxt   = idx_inc;
						state_nxt = S_SHIFT;
					end
				end else if (idx_inc == occ_q) begin
					res_status_nxt = STATUS_MISS;
					res_id_nxt     = '0;
					res_handle_nxt = '0;
					res_canc_nxt   = 1'b0;
					res_last_nxt   = 1'b1;
					state_nxt      = S_RESULT;
				end else begin
					idx_nxt = idx_inc;
				end
			end

			S_SHIFT: begin
				// close the gap: move younger entries down one place each cycle
				ptr       = idx_inc;
				cmd.wr_en = 1'b1;
				cmd.shift = 1'b1;
				if (idx_inc == occ_q) begin
					occ_nxt   = occ_q - CNT_W'(1);
					state_nxt = S_RESULT;
				end else begin
					idx_nxt = idx_inc;
				end
			end

			S_RESULT: begin
				out_valid = 1'b1;
				// head read for the next cancel all step
				ptr = '0;
				if (out_ready) begin
					if ((op_q == OP_CANCEL_ALL) && (occ_q != '0)) begin
						idx_nxt   = '0;
						state_nxt = S_SCAN;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end

			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign status     = res_status_q;
	assign entry_id   = res_id_q;
	assign out_handle = res_handle_q;
	assign canceled   = res_canc_q;
	assign last       = res_last_q;

endmodule

FILE: hdl/trq_checker.sv
// ----------------------------------------------------------------------------
// trq_port_checker: port-level checks for the tagged request queue
// watches handshakes and result fields, attached to the top level by bind
// ----------------------------------------------------------------------------
module trq_port_checker import trq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [1:0]          op,
	input logic [HANDLE_W-1:0] req_handle,
	input logic [ID_W-1:0]     target_id,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          status,
	input logic [ID_W-1:0]     entry_id,
	input logic [HANDLE_W-1:0] out_handle,
	input logic                canceled,
	input logic                last
);

	// one request at a time: never taking a request while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	// an accepted request blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an accepted request");

	// failed results carry no id, no handle, no cancel mark and end the request
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STATUS_OK)) |->
		(entry_id == '0) && (out_handle == '0) && !canceled && last)
		else $error("non-ok result with payload");

	// an accepted enqueue, full or not, shows its result on the next cycle
	a_enq_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op == OP_ENQ)) |=> out_valid)
		else $error("enqueue result not shown on the next cycle");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(status) && $stable(entry_id) && $stable(out_handle)
		&& $stable(canceled) && $stable(last)))
		else $error("result changed while stalled");

endmodule

bind tagged_request_queue_top trq_port_checker u_trq_checker (.*);
